[design/acc8_pkg.sv]
// Shared types and constants for the 8-bit accumulator machine.
// Holds the command and result item structs, command codes and opcodes.
// No dependencies.
package acc8_pkg;

  localparam int DATA_W    = 8;
  localparam int MEM_DEPTH = 256;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CMD_W     = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXEC  = 2'd2;

  // Opcodes (whole byte)
  localparam logic [DATA_W-1:0] OP_NOP = 8'h00;
  localparam logic [DATA_W-1:0] OP_STA = 8'h10;
  localparam logic [DATA_W-1:0] OP_LDA = 8'h20;
  localparam logic [DATA_W-1:0] OP_ADD = 8'h30;
  localparam logic [DATA_W-1:0] OP_OR  = 8'h40;
  localparam logic [DATA_W-1:0] OP_AND = 8'h50;
  localparam logic [DATA_W-1:0] OP_NOT = 8'h60;
  localparam logic [DATA_W-1:0] OP_JMP = 8'h80;
  localparam logic [DATA_W-1:0] OP_JN  = 8'h90;
  localparam logic [DATA_W-1:0] OP_JZ  = 8'hA0;
  localparam logic [DATA_W-1:0] OP_HLT = 8'hF0;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] write_byte;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_byte;
    logic [DATA_W-1:0] acc_value;
    logic [ADDR_W-1:0] prog_counter;
    logic              zero_flag;
    logic              neg_flag;
    logic              halted;
  } rsp_t;

endpackage

[design/acc8_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies; contents are not reset.
module acc8_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/accumulator_cpu_8bit_step.sv]
// 8-bit accumulator machine: 256-byte memory, accumulator, program counter, Z/N flags.
// Depends on acc8_pkg and acc8_ram.
//
// Usage:
//   The command channel (cmd_valid, cmd_stall, cmd_item) carries one item per
//   command: write a memory byte, read a memory byte, or execute one
//   instruction at the program counter. The result channel (rsp_valid,
//   rsp_stall, rsp_item) returns one item per command with the read byte,
//   accumulator, program counter, flags and the halted indication.
//   Commands are handled one at a time, all memory reads going through the
//   single read port of the main memory. An execute fetches the opcode and,
//   unless it is a HLT, the operand address, then for a load or ALU instruction
//   the data byte. Every command but an execute on a HLT then reads the byte at
//   the program counter for the halted indication. A new command is taken in
//   the idle state that follows the loading of the previous result.
//   The result sits in an output register: the next command is accepted while
//   it waits; if the receiver still stalls when the next result is ready, the
//   block holds that result and stalls the command channel.
//   Reset clears state, acc, pc, flags and rsp_valid at once; memory reads as
//   zero through one valid bit per entry, so there is no clearing pass.
module accumulator_cpu_8bit_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  acc8_pkg::cmd_t cmd_item,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output acc8_pkg::rsp_t rsp_item
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RDATA   = 3'd1;
  localparam logic [2:0] S_OP      = 3'd2;
  localparam logic [2:0] S_ADDR    = 3'd3;
  localparam logic [2:0] S_DATA    = 3'd4;
  localparam logic [2:0] S_HALT_RD = 3'd5;
  localparam logic [2:0] S_HALT    = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  logic [2:0]                  state;
  logic [acc8_pkg::DATA_W-1:0] acc;
  logic [acc8_pkg::ADDR_W-1:0] pc;
  logic                        z;
  logic                        n;
  logic [acc8_pkg::DATA_W-1:0] op;
  logic [acc8_pkg::DATA_W-1:0] rbyte;
  logic                        halted_r;
  logic [acc8_pkg::MEM_DEPTH-1:0] vld;
  logic                        rd_vld;

  logic                        accept;
  logic                        wr_en;
  logic [acc8_pkg::ADDR_W-1:0] wr_addr;
  logic [acc8_pkg::DATA_W-1:0] wr_data;
  logic [acc8_pkg::ADDR_W-1:0] rd_addr;
  logic [acc8_pkg::DATA_W-1:0] ram_q;
  logic [acc8_pkg::DATA_W-1:0] mem_q;
  logic [acc8_pkg::ADDR_W-1:0] pc_inc1;
  logic [acc8_pkg::ADDR_W-1:0] pc_inc2;
  logic                        rsp_free;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign pc_inc1   = pc + acc8_pkg::ADDR_W'(1);
  assign pc_inc2   = pc + acc8_pkg::ADDR_W'(2);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Mask entries never written since reset to zero
  assign mem_q = rd_vld ? ram_q : '0;

  // Select memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmd_item.mem_addr;
    wr_data = cmd_item.write_byte;
    if (state == S_IDLE && accept && cmd_item.cmd == acc8_pkg::CMD_WRITE) begin
      wr_en = 1'b1;
    end else if (state == S_ADDR && op == acc8_pkg::OP_STA) begin
      wr_en   = 1'b1;
      wr_addr = mem_q;
      wr_data = acc;
    end
  end

  // Select memory read address for the next cycle
  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = (cmd_item.cmd == acc8_pkg::CMD_READ) ? cmd_item.mem_addr : pc;
      S_OP:    rd_addr = pc_inc1;
      S_ADDR:  rd_addr = mem_q;
      S_DATA:  rd_addr = pc_inc2;
      default: rd_addr = pc;
    endcase
  end

  acc8_ram #(
    .WIDTH (acc8_pkg::DATA_W),
    .DEPTH (acc8_pkg::MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Track written entries and the valid bit of each read
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[rd_addr];
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  // Sequence each command through the memory
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      pc        <= '0;
      z         <= 1'b0;
      n         <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rbyte <= '0;
            if (cmd_item.cmd == acc8_pkg::CMD_READ) begin
              state <= S_RDATA;
            end else if (cmd_item.cmd == acc8_pkg::CMD_EXEC) begin
              state <= S_OP;
            end else begin
              state <= S_HALT_RD;
            end
          end
        end
        S_RDATA: begin
          rbyte <= mem_q;
          state <= S_HALT;
        end
        S_OP: begin
          if (mem_q == acc8_pkg::OP_HLT) begin
            halted_r <= 1'b1;
            state    <= S_OUT;
          end else begin
            z     <= (acc == '0);
            n     <= acc[acc8_pkg::DATA_W-1];
            op    <= mem_q;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_HALT_RD;
          case (op) inside
            acc8_pkg::OP_LDA, acc8_pkg::OP_ADD, acc8_pkg::OP_OR, acc8_pkg::OP_AND: begin
              state <= S_DATA;
            end
            acc8_pkg::OP_NOT: begin
              acc <= ~acc;
              pc  <= pc_inc1;
            end
            acc8_pkg::OP_JMP: pc <= mem_q;
            acc8_pkg::OP_JN:  pc <= n ? mem_q : pc_inc2;
            acc8_pkg::OP_JZ:  pc <= z ? mem_q : pc_inc2;
            default:          pc <= pc_inc2;
          endcase
        end
        S_DATA: begin
          case (op)
            acc8_pkg::OP_LDA: acc <= mem_q;
            acc8_pkg::OP_ADD: acc <= acc + mem_q;
            acc8_pkg::OP_OR:  acc <= acc | mem_q;
            acc8_pkg::OP_AND: acc <= acc & mem_q;
            default:          acc <= acc;
          endcase
          pc    <= pc_inc2;
          state <= S_HALT;
        end
        S_HALT_RD: begin
          state <= S_HALT;
        end
        S_HALT: begin
          halted_r <= (mem_q == acc8_pkg::OP_HLT);
          state    <= S_OUT;
        end
        S_OUT: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Load the result item
  always_ff @(posedge clk) begin
    if (state == S_OUT && rsp_free) begin
      rsp_item.read_byte    <= rbyte;
      rsp_item.acc_value    <= acc;
      rsp_item.prog_counter <= pc;
      rsp_item.zero_flag    <= z;
      rsp_item.neg_flag     <= n;
      rsp_item.halted       <= halted_r;
    end
  end

`ifndef SYNTH
  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output state");

  a_wr_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_IDLE || state == S_ADDR))
    else $error("memory write in an unexpected state");

  a_data_after_addr: assert property (@(posedge clk) disable iff (rst)
    state == S_DATA |-> $past(state) == S_ADDR)
    else $error("data fetch without operand address");

  a_op_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_OP |-> ($past(state) == S_IDLE && $past(cmd_item.cmd) == acc8_pkg::CMD_EXEC))
    else $error("opcode decode without an execute command");
`endif

endmodule

[tb/accumulator_cpu_8bit_step_tb.sv]
// Self-checking testbench for the 8-bit accumulator machine step block.
// Drives command items, predicts each result item and checks it field by field.
// Depends on acc8_pkg and accumulator_cpu_8bit_step.
module accumulator_cpu_8bit_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acc8_pkg::*;

  // Command code the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int TOTAL_ITEMS = 1120;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int TAIL_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd_item = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_item;

  // Machine state as predicted
  logic [DATA_W-1:0] mem_image [MEM_DEPTH];
  logic [DATA_W-1:0] acc_model;
  logic [ADDR_W-1:0] pc_model;
  logic z_model;
  logic n_model;

  cmd_t pending_cmds[$];
  rsp_t awaited_rsps[$];
  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_exec = 0;
  int n_halt_exec = 0;
  int n_errors = 0;
  int holdoffs = 0;
  int hold_left = 0;
  logic quiet;

  accumulator_cpu_8bit_step dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // No random idling on either side in the middle of the run
  assign quiet = (n_accepted >= 400) && (n_accepted < 600);

  // Apply one command to the predicted machine and return the result item
  function automatic rsp_t step_machine(cmd_t c);
    rsp_t r;
    logic [DATA_W-1:0] op;
    logic [DATA_W-1:0] opnd;
    logic [ADDR_W-1:0] next2;
    r = '0;
    case (c.cmd)
      CMD_WRITE: mem_image[c.mem_addr] = c.write_byte;
      CMD_READ:  r.read_byte = mem_image[c.mem_addr];
      CMD_EXEC: begin
        n_exec++;
        op = mem_image[pc_model];
        if (op == OP_HLT) begin
          n_halt_exec++;
        end else begin
          z_model = (acc_model == '0);
          n_model = acc_model[DATA_W-1];
          opnd = mem_image[ADDR_W'(pc_model + 1)];
          next2 = pc_model + ADDR_W'(2);
          case (op)
            OP_STA: begin mem_image[opnd] = acc_model; pc_model = next2; end
            OP_LDA: begin acc_model = mem_image[opnd]; pc_model = next2; end
            OP_ADD: begin acc_model = acc_model + mem_image[opnd]; pc_model = next2; end
            OP_OR:  begin acc_model = acc_model | mem_image[opnd]; pc_model = next2; end
            OP_AND: begin acc_model = acc_model & mem_image[opnd]; pc_model = next2; end
            OP_NOT: begin acc_model = ~acc_model; pc_model = pc_model + ADDR_W'(1); end
            OP_JMP: pc_model = opnd;
            OP_JN:  pc_model = n_model ? opnd : next2;
            OP_JZ:  pc_model = z_model ? opnd : next2;
            default: pc_model = next2;
          endcase
        end
      end
      default: ;
    endcase
    r.acc_value = acc_model;
    r.prog_counter = pc_model;
    r.zero_flag = z_model;
    r.neg_flag = n_model;
    r.halted = (mem_image[pc_model] == OP_HLT);
    return r;
  endfunction

  function automatic void push_item(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
                                    logic [DATA_W-1:0] b);
    cmd_t it;
    it.cmd = c;
    it.mem_addr = a;
    it.write_byte = b;
    pending_cmds.push_back(it);
    n_queued++;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  // Wait until every queued item is in and every result is back
  task automatic drain();
    wait (n_accepted == n_queued && awaited_rsps.size() == 0);
  endtask

  // Driver: predict on accept, then offer the next item unless stalled
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      for (int i = 0; i < MEM_DEPTH; i++) mem_image[i] = '0;
      acc_model = '0;
      pc_model = '0;
      z_model = 1'b0;
      n_model = 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        awaited_rsps.push_back(step_machine(cmd_item));
        n_accepted++;
      end
      if (!(cmd_valid && cmd_stall)) begin
        if (pending_cmds.size() > 0 && (quiet || $urandom_range(0, 99) >= 17)) begin
          cmd_item <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, then pick the next stall
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        n_results++;
        if (awaited_rsps.size() == 0) begin
          $error("result item with no expectation waiting: %p", rsp_item);
          n_errors++;
        end else begin
          want = awaited_rsps.pop_front();
          check_field("read_byte", want.read_byte, rsp_item.read_byte);
          check_field("acc_value", want.acc_value, rsp_item.acc_value);
          check_field("prog_counter", want.prog_counter, rsp_item.prog_counter);
          check_field("zero_flag", DATA_W'(want.zero_flag), DATA_W'(rsp_item.zero_flag));
          check_field("neg_flag", DATA_W'(want.neg_flag), DATA_W'(rsp_item.neg_flag));
          check_field("halted", DATA_W'(want.halted), DATA_W'(rsp_item.halted));
        end
      end
      // Hold off for a long stretch twice so the block backs up
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_stall <= 1'b1;
      end else if (pending_cmds.size() > 2 &&
                   ((n_accepted >= 200 && holdoffs == 0) ||
                    (n_accepted >= 700 && holdoffs == 1))) begin
        hold_left <= HOLDOFF_CYCLES;
        holdoffs <= holdoffs + 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !quiet && ($urandom_range(0, 99) < 17);
      end
    end
  end

  // Stimulus
  initial begin
    logic [ADDR_W-1:0] p;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] data_base;
    logic [DATA_W-1:0] op;
    logic [DATA_W-1:0] val;
    int len;
    int nexec;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: unused command, address and byte extremes, ADD wrap, NOT,
    // halt and execute while halted, jump and PC wrap past 0xFF
    push_item(CMD_UNUSED, 8'hFF, 8'hFF);
    push_item(CMD_WRITE, 8'hFF, 8'hFF);
    push_item(CMD_READ, 8'hFF, 8'h00);
    push_item(CMD_WRITE, 8'h00, OP_LDA);
    push_item(CMD_WRITE, 8'h01, 8'hFF);
    push_item(CMD_WRITE, 8'h02, OP_ADD);
    push_item(CMD_WRITE, 8'h03, 8'hFF);
    push_item(CMD_WRITE, 8'h04, OP_NOT);
    push_item(CMD_WRITE, 8'h05, OP_HLT);
    repeat (5) push_item(CMD_EXEC, 8'h00, 8'h00);
    push_item(CMD_WRITE, 8'h05, OP_JMP);
    push_item(CMD_WRITE, 8'h06, 8'hFE);
    push_item(CMD_WRITE, 8'hFE, OP_JZ);
    repeat (2) push_item(CMD_EXEC, 8'hFF, 8'hFF);
    push_item(CMD_READ, 8'h00, 8'hFF);
    push_item(CMD_UNUSED, 8'h00, 8'h00);
    drain();

    // Random: mostly short programs placed at the current PC, then executed
    while (n_queued < TOTAL_ITEMS) begin
      if ($urandom_range(0, 99) < 80) begin
        start = pc_model;
        p = start;
        data_base = ADDR_W'($urandom_range(0, 255));
        len = $urandom_range(2, 6);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 11))
            0: op = OP_STA;
            1: op = OP_LDA;
            2: op = OP_ADD;
            3: op = OP_OR;
            4: op = OP_AND;
            5: op = OP_NOT;
            6: op = OP_JMP;
            7: op = OP_JN;
            8: op = OP_JZ;
            9: op = OP_NOP;
            10: op = ($urandom_range(0, 3) == 0) ? OP_HLT : DATA_W'($urandom_range(0, 255));
            default: op = OP_LDA;
          endcase
          push_item(CMD_WRITE, p, op);
          p = p + ADDR_W'(1);
          if (op != OP_NOT) begin
            if (op == OP_JMP || op == OP_JN || op == OP_JZ)
              val = ($urandom_range(0, 1) == 0) ? start : DATA_W'($urandom_range(0, 255));
            else
              val = data_base + DATA_W'($urandom_range(0, 3));
            push_item(CMD_WRITE, p, val);
            p = p + ADDR_W'(1);
          end
        end
        // Seed operands with values that drive both flags
        for (int j = 0; j < 4; j++) begin
          case ($urandom_range(0, 4))
            0: val = 8'h00;
            1: val = 8'h7F;
            2: val = 8'h80;
            3: val = 8'hFF;
            default: val = DATA_W'($urandom_range(0, 255));
          endcase
          push_item(CMD_WRITE, data_base + ADDR_W'(j), val);
        end
        nexec = $urandom_range(1, 2 * len + 2);
        for (int i = 0; i < nexec; i++) begin
          if ($urandom_range(0, 9) == 0)
            push_item(CMD_READ, ADDR_W'($urandom_range(0, 255)),
                      DATA_W'($urandom_range(0, 255)));
          push_item(CMD_EXEC, ADDR_W'($urandom_range(0, 255)),
                    DATA_W'($urandom_range(0, 255)));
        end
      end else begin
        // Noise: any command with any fields
        repeat ($urandom_range(3, 12))
          push_item(CMD_W'($urandom_range(0, 3)), ADDR_W'($urandom_range(0, 255)),
                    DATA_W'($urandom_range(0, 255)));
      end
      drain();
    end

    // Catch any stray result after the last one
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d commands with %0d results: %0d executes, %0d on a halt, %0d hold-offs",
             n_accepted, n_results, n_exec, n_halt_exec, holdoffs);
    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Give up after a generous fixed time
  initial begin
    #3000000;
    $display("Timeout with %0d results still awaited", awaited_rsps.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
